// ----- rtl/spectrum_band_bar_aggregator_assert.svh -----
// assertion macros for the spectrum band bar aggregator checker
`ifndef SPECTRUM_BAND_BAR_AGGREGATOR_ASSERT_SVH
`define SPECTRUM_BAND_BAR_AGGREGATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SBBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spectrum band bar aggregator check failed");

// next-cycle implication, sampled on clk, off during reset
`define SBBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spectrum band bar aggregator check failed");

`endif

// ----- rtl/sbba_pkg.sv -----
// shared types, constants and tables for the spectrum band bar aggregator
`default_nettype none

package sbba_pkg;

  localparam int NUM_BANDS = 8;
  localparam int POS_W     = 12;
  localparam int MAG_W     = 24;
  localparam int SUM_W     = 34;
  localparam int FPU_W     = 4;
  localparam int LVL_W     = 4;
  localparam int COL_W     = 16;
  localparam int BAND_W    = 3;
  localparam int SUM_LIMIT = 2048;

  localparam logic [LVL_W-1:0] MAX_LEVEL = 4'd8;
  localparam logic [BAND_W-1:0] LAST_BAND = 3'd7;

  localparam logic [1:0] REG_NOISE_THR  = 2'd0;
  localparam logic [1:0] REG_BAND_SCALE = 2'd1;
  localparam logic [1:0] REG_FPU        = 2'd2;

  localparam logic [MAG_W-1:0] NOISE_THR_RST  = 24'd1280;
  localparam logic [MAG_W-1:0] BAND_SCALE_RST = 24'd51200;
  localparam logic [FPU_W-1:0] FPU_RST        = 4'd2;

  localparam logic [1:0] COL_OFF    = 2'd0;
  localparam logic [1:0] COL_GREEN  = 2'd1;
  localparam logic [1:0] COL_YELLOW = 2'd2;
  localparam logic [1:0] COL_RED    = 2'd3;

  // upper edge of each band, exclusive
  localparam logic [POS_W-1:0] BAND_UPPER [NUM_BANDS] = '{
    12'd10, 12'd47, 12'd140, 12'd279, 12'd465, 12'd743, 12'd1115, 12'd2048
  };

  // floor(height / frames) for height 0..8, frames 1..8 (index frames - 1)
  localparam logic [LVL_W-1:0] HEIGHT_DIV [9][8] = '{
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd3, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd4, 4'd2, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd5, 4'd2, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0},
    '{4'd6, 4'd3, 4'd2, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0},
    '{4'd7, 4'd3, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0},
    '{4'd8, 4'd4, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  typedef struct packed {
    logic              accept;
    logic              div_en;
    logic [1:0]        div_shift;
    logic              apply;
    logic              emit_load;
    logic [BAND_W-1:0] emit_band;
    logic              emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic needs_close;
    logic frame_emit;
    logic out_free;
  } dp_stat_t;

  function automatic logic [COL_W-1:0] row_colours_for(input logic [LVL_W-1:0] lvl);
    logic [COL_W-1:0] c;
    c = '0;
    for (int r = 0; r < 8; r++) begin
      if (lvl > LVL_W'(r)) begin
        c[2*r +: 2] = (r >= 7) ? COL_RED : (r >= 4) ? COL_YELLOW : COL_GREEN;
      end else begin
        c[2*r +: 2] = COL_OFF;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sbba_ctrl.sv -----
// controller state machine: accept, band divide, level update, result emission
`default_nettype none

module sbba_ctrl
  import sbba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire dp_stat_t   stat,
  output ctrl_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [BAND_W-1:0] emit_cnt_r, emit_cnt_nxt;
  logic              emit_pend_r, emit_pend_nxt;
  logic              accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    emit_cnt_nxt  = emit_cnt_r;
    emit_pend_nxt = emit_pend_r;
    cmd           = '0;
    cmd.div_shift = ~step_r;
    cmd.emit_band = emit_cnt_r;
    cmd.emit_last = (emit_cnt_r == LAST_BAND);
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = accept;
        if (accept) begin
          if (stat.is_clear) begin
            state_nxt    = S_EMIT;
            emit_cnt_nxt = '0;
          end else if (stat.needs_close) begin
            state_nxt     = S_DIV;
            step_nxt      = '0;
            emit_pend_nxt = stat.frame_emit;
          end
        end
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        step_nxt   = 2'(step_r + 2'd1);
        if (step_r == 2'd3) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (emit_pend_r) begin
          state_nxt    = S_EMIT;
          emit_cnt_nxt = '0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          emit_cnt_nxt  = BAND_W'(emit_cnt_r + 3'd1);
          if (emit_cnt_r == LAST_BAND) begin
            state_nxt     = S_IDLE;
            emit_pend_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      emit_cnt_r  <= '0;
      emit_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      emit_pend_r <= emit_pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sbba_dp.sv -----
// datapath: band sums, band levels, restoring divider, config and output register
`default_nettype none

module sbba_dp
  import sbba_pkg::*;
#(
  parameter int NUM_BINS = 2048
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [MAG_W-1:0]  cfg_data,
  input  wire logic              in_command,
  input  wire logic [MAG_W-1:0]  in_magnitude,
  input  wire ctrl_cmd_t         cmd,
  output dp_stat_t               stat,
  input  wire logic              out_tready,
  output logic                   out_valid,
  output logic [BAND_W-1:0]      out_band,
  output logic [LVL_W-1:0]       out_level,
  output logic [COL_W-1:0]       out_colours,
  output logic                   out_last
);

  localparam int SumEnd = (SUM_LIMIT < NUM_BINS - 1) ? SUM_LIMIT : NUM_BINS - 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_BINS - 1);
  localparam logic [POS_W-1:0] SUM_END  = POS_W'(SumEnd);

  logic [MAG_W-1:0]  thr_r, scale_r;
  logic [FPU_W-1:0]  fpu_r;
  logic [POS_W-1:0]  pos_r;
  logic [BAND_W-1:0] band_r, div_band_r;
  logic [SUM_W-1:0]  sum_r, rem_r;
  logic [LVL_W-1:0]  quo_r;
  logic [2:0]        phase_r;
  logic [LVL_W-1:0]  level_r [NUM_BANDS];
  logic              out_valid_r, out_last_r;
  logic [BAND_W-1:0] out_band_r;
  logic [LVL_W-1:0]  out_level_r;
  logic [COL_W-1:0]  out_colours_r;

  logic [SUM_W-1:0]  sum_add, div_d;
  logic              close_mid, last_bin, do_emit;
  logic [2:0]        phase_inc;
  logic [FPU_W-1:0]  fpu_eff;
  logic [MAG_W-1:0]  scale_eff;
  logic [BAND_W-1:0] lvl_addr;
  logic [LVL_W-1:0]  lvl_rd, height, height_q, lvl_new;
  logic [LVL_W:0]    lvl_sum;

  assign fpu_eff   = (fpu_r == '0) ? FPU_W'(1) : (fpu_r > FPU_W'(8)) ? FPU_W'(8) : fpu_r;
  assign scale_eff = (scale_r == '0) ? MAG_W'(1) : scale_r;

  assign sum_add   = ((pos_r < SUM_END) && (in_magnitude > thr_r))
                     ? SUM_W'(sum_r + SUM_W'(in_magnitude)) : sum_r;
  assign close_mid = (band_r != LAST_BAND)
                     && ((13'(pos_r) + 13'd1) == 13'(BAND_UPPER[band_r]));
  assign last_bin  = (pos_r >= LAST_POS);
  assign phase_inc = 3'(phase_r + 3'd1);
  assign do_emit   = (phase_inc == 3'd0) || (FPU_W'(phase_inc) >= fpu_eff);

  assign stat.is_clear    = in_command;
  assign stat.needs_close = !in_command && (close_mid || last_bin);
  assign stat.frame_emit  = !in_command && last_bin && do_emit;
  assign stat.out_free    = !out_valid_r || out_tready;

  assign div_d    = SUM_W'(scale_eff) << cmd.div_shift;
  assign lvl_addr = cmd.emit_load ? cmd.emit_band : div_band_r;
  assign lvl_rd   = level_r[lvl_addr];
  assign height   = quo_r[LVL_W-1] ? MAX_LEVEL : quo_r;
  assign height_q = HEIGHT_DIV[height][3'(fpu_eff - FPU_W'(1))];
  assign lvl_sum  = (LVL_W+1)'(lvl_rd) + (LVL_W+1)'(height_q);
  assign lvl_new  = (lvl_sum > (LVL_W+1)'(MAX_LEVEL)) ? MAX_LEVEL : lvl_sum[LVL_W-1:0];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= NOISE_THR_RST;
      scale_r <= BAND_SCALE_RST;
      fpu_r   <= FPU_RST;
    end else if (cfg_wr) begin
      if (cfg_index == REG_NOISE_THR) begin
        thr_r <= cfg_data;
      end
      if (cfg_index == REG_BAND_SCALE) begin
        scale_r <= cfg_data;
      end
      if (cfg_index == REG_FPU) begin
        fpu_r <= cfg_data[FPU_W-1:0];
      end
    end
  end

  // frame position, band tracking and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      band_r     <= '0;
      sum_r      <= '0;
      phase_r    <= '0;
      div_band_r <= '0;
    end else if (cmd.accept) begin
      if (in_command) begin
        sum_r <= '0;
      end else begin
        if (close_mid) begin
          sum_r      <= '0;
          div_band_r <= band_r;
          band_r     <= BAND_W'(band_r + 3'd1);
        end else if (last_bin) begin
          sum_r      <= '0;
          div_band_r <= LAST_BAND;
        end else begin
          sum_r <= sum_add;
        end
        if (last_bin) begin
          pos_r   <= '0;
          band_r  <= '0;
          phase_r <= do_emit ? 3'd0 : phase_inc;
        end else begin
          pos_r <= POS_W'(pos_r + 12'd1);
        end
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rem_r <= sum_add;
      quo_r <= '0;
    end else if (cmd.div_en && (rem_r >= div_d)) begin
      rem_r                <= rem_r - div_d;
      quo_r[cmd.div_shift] <= 1'b1;
    end
  end

  // band levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        level_r[b] <= '0;
      end
    end else if ((cmd.accept && in_command) || (cmd.emit_load && cmd.emit_last)) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        level_r[b] <= '0;
      end
    end else if (cmd.apply) begin
      level_r[div_band_r] <= lvl_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_band_r    <= cmd.emit_band;
      out_level_r   <= lvl_rd;
      out_colours_r <= row_colours_for(lvl_rd);
      out_last_r    <= cmd.emit_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_band    = out_band_r;
  assign out_level   = out_level_r;
  assign out_colours = out_colours_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/spectrum_band_bar_aggregator.sv -----
// top level of the spectrum band bar aggregator
//
// in_*  : one request per FFT magnitude bin in frame order, or a clear request
//         (in_tuser = 1). in_tdata holds the Q16.8 magnitude.
// out_* : one result per band column: band number in out_tuser, lit row count
//         and 2-bit row colours in out_tdata, out_tlast on band 7.
// cfg_* : register writes (noise threshold, band scale, frames per update),
//         always ready; write only while no request is in flight.
// A bin that closes no band leaves the input ready, so such bins stream back to back.
// A bin that closes a band goes through accept, the steps of the restoring
// divider (one quotient bit each, height saturated at 8) and a level update.
// Every frames_per_update frames, and on each clear, 8 results follow at one
// per cycle from the output register; input stays blocked until the eighth
// result is loaded. A stalled receiver holds the output register and stretches
// the emission; the next request is taken while the last result still waits.
// Reset clears position, band, sums, levels and frame phase and loads the
// register defaults (1280, 51200, 2).
`default_nettype none

module spectrum_band_bar_aggregator
  import sbba_pkg::*;
#(
  parameter int NUM_BINS = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [23:0] magnitude
  input  wire logic [0:0]  in_tuser,   // [0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [3:0] level, [19:4] row_colours, [23:20] zero
  output logic [2:0]       out_tuser,  // [2:0] band_number
  output logic             out_tlast   // last_band
);

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [LVL_W-1:0]  out_level;
  logic [COL_W-1:0]  out_colours;

  assign cfg_ready = 1'b1;

  sbba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sbba_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_command   (in_tuser[0]),
    .in_magnitude (in_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .out_band     (out_tuser),
    .out_level    (out_level),
    .out_colours  (out_colours),
    .out_last     (out_tlast)
  );

  assign out_tdata = {4'd0, out_colours, out_level};

endmodule

`default_nettype wire

// ----- rtl/sbba_checker.sv -----
// port checker for the spectrum band bar aggregator and its bind
`default_nettype none

`include "spectrum_band_bar_aggregator_assert.svh"

module sbba_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  `SBBA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SBBA_ASSERT_NOW(a_level_range, out_tvalid, out_tdata[3:0] <= 4'd8)
  `SBBA_ASSERT_NOW(a_dark_column, out_tvalid && (out_tdata[3:0] == 4'd0), out_tdata[23:4] == 20'd0)
  `SBBA_ASSERT_NOW(a_last_band, out_tvalid, out_tlast == (out_tuser == 3'd7))

endmodule

bind spectrum_band_bar_aggregator sbba_checker u_sbba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
